/* src/row_projection_edge_finder_top_defines.svh */
// Assertion macros shared by the checker of the row projection edge finder.
// No dependencies; include this file by its bare name.
`ifndef ROW_PROJECTION_EDGE_FINDER_TOP_DEFINES_SVH
`define ROW_PROJECTION_EDGE_FINDER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RPEF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("row projection edge finder: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define RPEF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("row projection edge finder: next-cycle check failed");

`endif

/* src/rpef_pkg.sv */
// Types and constants of the row projection edge finder.
// No dependencies; used by the front end, queue, back end and top level of the block.
package rpef_pkg;

  localparam int PIXEL_W = 8;
  localparam int ADDR_W = 12;
  localparam int SUM_W = 16;
  localparam int MEAN_W = 8;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_INDEX_W = 2;
  localparam int MAX_WINDOW_WIDTH = 256;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_EDGE_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_DISTANCE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_WIDTH = 2'd2;

  typedef struct packed {
    logic [7:0] edge_threshold;
    logic [6:0] compare_distance;
    logic [8:0] window_width;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [ADDR_W-1:0] addr;
    logic last;
  } row_rec_t;

endpackage

/* src/rpef_front.sv */
// Front end: accumulates pixels of a row and emits one row record per closed row.
// Depends on rpef_pkg.
module rpef_front
  import rpef_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [PIXEL_W-1:0] pixel,
  input  logic [ADDR_W-1:0] row_address,
  input  logic row_end,
  input  logic window_end,
  input  logic q_full,
  output logic push,
  output row_rec_t rec
);

  logic [SUM_W-1:0] acc;
  logic [SUM_W:0] sum_wide;
  logic [SUM_W-1:0] sum_sat;
  logic accept;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign sum_wide = {1'b0, acc} + (SUM_W+1)'(pixel);
  assign sum_sat = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

  assign push = accept && (row_end || window_end);
  assign rec.sum = sum_sat;
  assign rec.addr = row_address;
  assign rec.last = window_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (accept) begin
      acc <= (row_end || window_end) ? '0 : sum_sat;
    end
  end

endmodule

/* src/rpef_queue.sv */
// Short queue of row records between the front and the back end.
// Depends on rpef_pkg.
module rpef_queue
  import rpef_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  row_rec_t rec_in,
  output logic full,
  input  logic pop,
  output logic rec_valid,
  output row_rec_t rec_out
);

  row_rec_t slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0] count;
  logic do_pop;

  assign full = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign rec_valid = (count != '0);
  assign rec_out = slots[rd_ptr];
  assign do_pop = pop && rec_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= rec_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, do_pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/rpef_back.sv */
// Back end: divides each row sum, keeps the mean and address history and tracks the edge.
// Depends on rpef_pkg; history memories are internal.
module rpef_back
  import rpef_pkg::*;
#(
  parameter int MAX_DISTANCE = 64
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic rec_valid,
  input  row_rec_t rec_in,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output logic edge_found,
  output logic [ADDR_W-1:0] edge_row
);

  localparam int PW = $clog2(MAX_DISTANCE);
  localparam int DW = $clog2(MAX_DISTANCE + 1);
  localparam int SW = DW + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  row_rec_t rec;
  logic [8:0] divisor;
  logic [8:0] dist_sel;
  logic [DW-1:0] cmp_dist;
  logic [DW-1:0] dist_half;

  logic [8:0] rem;
  logic [7:0] shift_lo;
  logic [MEAN_W-1:0] quo;
  logic [2:0] cnt;
  logic overflow;
  logic [9:0] trial;
  logic trial_ok;
  logic [MEAN_W-1:0] mean;

  logic [MEAN_W-1:0] mean_mem [MAX_DISTANCE];
  logic [ADDR_W-1:0] addr_mem [MAX_DISTANCE];
  logic [MEAN_W-1:0] old_mean;
  logic [ADDR_W-1:0] mid_addr;
  logic [PW-1:0] wr_ptr;
  logic [DW-1:0] rows_seen;
  logic hit_flag;
  logic [ADDR_W-1:0] hit_row;

  logic commit;
  logic hit_now;
  logic hit_flag_next;
  logic [ADDR_W-1:0] hit_row_next;

  function automatic logic [PW-1:0] slot_back(input logic [PW-1:0] wp, input logic [DW-1:0] k);
    logic [SW-1:0] diff;
    diff = SW'(wp) - SW'(k);
    if (diff[SW-1]) begin
      diff = diff + SW'(MAX_DISTANCE);
    end
    return diff[PW-1:0];
  endfunction

  always_comb begin
    priority if (cfg.window_width == '0) begin
      divisor = 9'd1;
    end else if (cfg.window_width > 9'(MAX_WINDOW_WIDTH)) begin
      divisor = 9'(MAX_WINDOW_WIDTH);
    end else begin
      divisor = cfg.window_width;
    end
    priority if (cfg.compare_distance == '0) begin
      dist_sel = 9'd1;
    end else if ({2'b00, cfg.compare_distance} > 9'(MAX_DISTANCE)) begin
      dist_sel = 9'(MAX_DISTANCE);
    end else begin
      dist_sel = {2'b00, cfg.compare_distance};
    end
  end

  assign cmp_dist = dist_sel[DW-1:0];
  assign dist_half = cmp_dist - (cmp_dist >> 1);

  assign trial = {rem, shift_lo[7]};
  assign trial_ok = (trial >= {1'b0, divisor});
  assign mean = overflow ? {MEAN_W{1'b1}} : quo;
  assign pop = (state == ST_IDLE);

  assign commit = (state == ST_DONE) && !(rec.last && out_valid && !out_ready);
  assign hit_now = !hit_flag && (rows_seen >= cmp_dist) && (old_mean > mean)
    && ((old_mean - mean) > cfg.edge_threshold);
  assign hit_flag_next = hit_flag || hit_now;
  assign hit_row_next = hit_now ? mid_addr : hit_row;

  always_ff @(posedge clk) begin
    if (commit) begin
      mean_mem[wr_ptr] <= mean;
      addr_mem[wr_ptr] <= rec.addr;
    end
    if (state == ST_READ) begin
      old_mean <= mean_mem[slot_back(wr_ptr, cmp_dist)];
      mid_addr <= addr_mem[slot_back(wr_ptr, dist_half)];
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        rec <= rec_in;
        overflow <= ({1'b0, rec_in.sum[15:8]} >= divisor);
        rem <= {1'b0, rec_in.sum[15:8]};
        shift_lo <= rec_in.sum[7:0];
        cnt <= '0;
      end
      ST_DIV: begin
        rem <= trial_ok ? 9'(trial - {1'b0, divisor}) : trial[8:0];
        quo <= {quo[MEAN_W-2:0], trial_ok};
        shift_lo <= {shift_lo[6:0], 1'b0};
        cnt <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wr_ptr <= '0;
      rows_seen <= '0;
      hit_flag <= 1'b0;
      hit_row <= '0;
      out_valid <= 1'b0;
    end else begin
      if (commit && rec.last) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (rec_valid) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt == 3'd7) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (commit) begin
            state <= ST_IDLE;
            wr_ptr <= (wr_ptr == PW'(MAX_DISTANCE - 1)) ? '0 : wr_ptr + 1'b1;
            if (rec.last) begin
              rows_seen <= '0;
              hit_flag <= 1'b0;
              hit_row <= '0;
              edge_found <= hit_flag_next;
              edge_row <= hit_flag_next ? hit_row_next : '0;
            end else begin
              if (rows_seen != DW'(MAX_DISTANCE)) begin
                rows_seen <= rows_seen + 1'b1;
              end
              hit_flag <= hit_flag_next;
              hit_row <= hit_row_next;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* src/row_projection_edge_finder_top.sv */
// Row projection edge finder: pixels of a column window stream in row by row. The
// front end takes one pixel per cycle and sums each row; a closed row is queued
// (up to four rows) for the back end, which takes each row in turn through taking
// the row, the bit-serial division by the window width, the history memory read
// and the commit. Pixels are taken every cycle while the queue has room, so rows
// no shorter than the back end's work on a row stream without stalls as long as
// results are taken promptly; a window's last row waits in the back end while the
// previous result item is still unaccepted. One result item leaves on each window
// end, after that window's last row has been processed.
// Depends on rpef_pkg, rpef_front, rpef_queue and rpef_back.
module row_projection_edge_finder_top
  import rpef_pkg::*;
#(
  parameter int MAX_DISTANCE = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [PIXEL_W-1:0] pixel,
  input  logic [ADDR_W-1:0] row_address,
  input  logic row_end,
  input  logic window_end,
  output logic out_valid,
  input  logic out_ready,
  output logic edge_found,
  output logic [ADDR_W-1:0] edge_row
);

  cfg_t cfg;
  logic q_full;
  logic push;
  row_rec_t push_rec;
  logic pop;
  logic rec_valid;
  row_rec_t rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.edge_threshold <= 8'd0;
      cfg.compare_distance <= 7'd1;
      cfg.window_width <= 9'd200;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EDGE_THRESHOLD: cfg.edge_threshold <= cfg_data[7:0];
        REG_COMPARE_DISTANCE: cfg.compare_distance <= cfg_data[6:0];
        REG_WINDOW_WIDTH: cfg.window_width <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rpef_front u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel(pixel),
    .row_address(row_address),
    .row_end(row_end),
    .window_end(window_end),
    .q_full(q_full),
    .push(push),
    .rec(push_rec)
  );

  rpef_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .rec_in(push_rec),
    .full(q_full),
    .pop(pop),
    .rec_valid(rec_valid),
    .rec_out(rec)
  );

  rpef_back #(
    .MAX_DISTANCE(MAX_DISTANCE)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .rec_valid(rec_valid),
    .rec_in(rec),
    .pop(pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .edge_found(edge_found),
    .edge_row(edge_row)
  );

endmodule

/* src/rpef_checker.sv */
// Port-level checks of the row projection edge finder, bound to its top level.
// Depends on row_projection_edge_finder_top_defines.svh.
`include "row_projection_edge_finder_top_defines.svh"

module rpef_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic edge_found,
  input logic [11:0] edge_row
);

  `RPEF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `RPEF_ASSERT_IMPLY(a_no_edge_zero_row, clk, rst, out_valid && !edge_found, edge_row == 12'd0)
  `RPEF_ASSERT_NEXT(a_row_stable, clk, rst, out_valid && !out_ready, $stable(edge_row) && $stable(edge_found))

endmodule

bind row_projection_edge_finder_top rpef_checker u_rpef_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .edge_found(edge_found),
  .edge_row(edge_row)
);

/* dv/tb_row_projection_edge_finder_top.sv */
// Self-checking testbench for row_projection_edge_finder_top: drives pixel items of column
// windows, predicts each window's edge report in a behavioral model and compares the results.
// Depends on rpef_pkg and the row_projection_edge_finder_top RTL.
module tb_row_projection_edge_finder_top;
  import rpef_pkg::*;

  localparam int HISTORY_DEPTH = 64;
  localparam int DRAIN_SLACK = 80;
  localparam int RANDOM_ITEMS = 400;
  localparam int RANDOM_WINDOWS = 24;
  localparam int FIXED_PHASES = 7;

  typedef struct packed {
    logic found;
    logic [ADDR_W-1:0] row;
  } edge_result_t;

  typedef enum logic {STEP_PIXEL, STEP_CONFIG} step_kind_t;

  typedef struct packed {
    step_kind_t kind;
    logic [7:0] pix;
    logic [11:0] addr;
    logic closes_row;
    logic closes_window;
    logic typed;
    logic found;
    logic [11:0] row;
    logic [7:0] thr;
    logic [6:0] cmp_dist;
    logic [8:0] width;
  } plan_step_t;

  localparam plan_step_t DIRECTED_PLAN [22] = '{
    '{STEP_PIXEL, 8'd0, 12'd0, 1'b0, 1'b1, 1'b1, 1'b0, 12'd0, 8'd0, 7'd0, 9'd0},
    '{STEP_CONFIG, 8'd0, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0, 8'd0, 7'd1, 9'd1},
    '{STEP_PIXEL, 8'd255, 12'hFFF, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0, 8'd0, 7'd0, 9'd0},
    '{STEP_PIXEL, 8'd255, 12'hFFF, 1'b1, 1'b0, 1'b0, 1'b0, 12'd0, 8'd0, 7'd0, 9'd0},
    '{STEP_PIXEL, 8'd0, 12'd1, 1'b1, 1'b0, 1'b0, 1'b0, 12'd0, 8'd0, 7'd0, 9'd0},
    '{STEP_PIXEL, 8'd0, 12'd2, 1'b1, 1'b1, 1'b1, 1'b1, 12'hFFF, 8'd0, 7'd0, 9'd0},
    '{STEP_CONFIG, 8'd0, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0, 8'd255, 7'd1, 9'd1},
    '{STEP_PIXEL, 8'd255, 12'd10, 1'b1, 1'b0, 1'b0, 1'b0, 12'd0, 8'd0, 7'd0, 9'd0},
    '{STEP_PIXEL, 8'd0, 12'd11, 1'b1, 1'b1, 1'b1, 1'b0, 12'd0, 8'd0, 7'd0, 9'd0},
    '{STEP_CONFIG, 8'd0, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0, 8'd254, 7'd0, 9'd0},
    '{STEP_PIXEL, 8'd255, 12'd20, 1'b1, 1'b0, 1'b0, 1'b0, 12'd0, 8'd0, 7'd0, 9'd0},
    '{STEP_PIXEL, 8'd0, 12'd21, 1'b0, 1'b1, 1'b1, 1'b1, 12'd20, 8'd0, 7'd0, 9'd0},
    '{STEP_CONFIG, 8'd0, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0, 8'd0, 7'd2, 9'd1},
    '{STEP_PIXEL, 8'd100, 12'd40, 1'b1, 1'b0, 1'b0, 1'b0, 12'd0, 8'd0, 7'd0, 9'd0},
    '{STEP_PIXEL, 8'd90, 12'd41, 1'b1, 1'b0, 1'b0, 1'b0, 12'd0, 8'd0, 7'd0, 9'd0},
    '{STEP_PIXEL, 8'd80, 12'd42, 1'b1, 1'b0, 1'b0, 1'b0, 12'd0, 8'd0, 7'd0, 9'd0},
    '{STEP_PIXEL, 8'd0, 12'd43, 1'b0, 1'b1, 1'b0, 1'b0, 12'd0, 8'd0, 7'd0, 9'd0},
    '{STEP_CONFIG, 8'd0, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0, 8'd3, 7'd3, 9'd511},
    '{STEP_PIXEL, 8'd200, 12'h555, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0, 8'd0, 7'd0, 9'd0},
    '{STEP_PIXEL, 8'd200, 12'hAAA, 1'b1, 1'b0, 1'b0, 1'b0, 12'd0, 8'd0, 7'd0, 9'd0},
    '{STEP_PIXEL, 8'd7, 12'h123, 1'b1, 1'b0, 1'b0, 1'b0, 12'd0, 8'd0, 7'd0, 9'd0},
    '{STEP_PIXEL, 8'd0, 12'hFED, 1'b0, 1'b1, 1'b0, 1'b0, 12'd0, 8'd0, 7'd0, 9'd0}
  };

  localparam logic [7:0] FIXED_THR [FIXED_PHASES] =
    '{8'd0, 8'd255, 8'd20, 8'd40, 8'd10, 8'd60, 8'd5};
  localparam logic [6:0] FIXED_DIST [FIXED_PHASES] =
    '{7'd1, 7'd127, 7'd64, 7'd65, 7'd0, 7'd2, 7'd7};
  localparam logic [8:0] FIXED_WIDTH [FIXED_PHASES] =
    '{9'd4, 9'd511, 9'd1, 9'd257, 9'd0, 9'd256, 9'd9};

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [PIXEL_W-1:0] pixel;
  logic [ADDR_W-1:0] row_address;
  logic row_end;
  logic window_end;
  logic out_valid;
  logic out_ready;
  logic edge_found;
  logic [ADDR_W-1:0] edge_row;

  // Register copies and model state, at their reset values.
  logic [7:0] thr_reg = 8'd0;
  logic [6:0] dist_reg = 7'd1;
  logic [8:0] width_reg = 9'd200;
  int unsigned row_sum = 0;
  logic [7:0] mean_ring [HISTORY_DEPTH];
  logic [11:0] addr_ring [HISTORY_DEPTH];
  int unsigned ring_ptr = 0;
  int unsigned rows_held = 0;
  bit hit_seen = 1'b0;
  logic [11:0] hit_addr = '0;

  edge_result_t expected_edges [$];
  int mismatches = 0;
  int unsigned pixels_sent = 0;
  int unsigned windows_sent = 0;
  bit sender_burst = 1'b0;
  bit receiver_burst = 1'b0;
  int unsigned hold_cycles;

  row_projection_edge_finder_top #(
    .MAX_DISTANCE(HISTORY_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel(pixel),
    .row_address(row_address),
    .row_end(row_end),
    .window_end(window_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .edge_found(edge_found),
    .edge_row(edge_row)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned effective_distance();
    if (dist_reg == 7'd0) return 1;
    if (dist_reg > HISTORY_DEPTH) return HISTORY_DEPTH;
    return dist_reg;
  endfunction

  function automatic void model_pixel(input logic [7:0] pix, input logic [11:0] addr,
                                      input bit closes_row, input bit closes_window,
                                      output bit has_result, output edge_result_t res);
    int unsigned divisor;
    int unsigned cmp_dist;
    int unsigned mean;
    int unsigned old_mean;
    has_result = 1'b0;
    res = '0;
    row_sum = row_sum + pix;
    if (row_sum > 65535) row_sum = 65535;
    if (closes_row || closes_window) begin
      divisor = (width_reg == 9'd0) ? 1 : ((width_reg > MAX_WINDOW_WIDTH) ? MAX_WINDOW_WIDTH
                                                                           : width_reg);
      mean = row_sum / divisor;
      if (mean > 255) mean = 255;
      cmp_dist = effective_distance();
      if (!hit_seen && rows_held >= cmp_dist) begin
        old_mean = mean_ring[(ring_ptr + HISTORY_DEPTH - cmp_dist) % HISTORY_DEPTH];
        if (old_mean > mean && old_mean - mean > thr_reg) begin
          hit_seen = 1'b1;
          hit_addr = addr_ring[(ring_ptr + HISTORY_DEPTH - (cmp_dist - cmp_dist / 2))
                               % HISTORY_DEPTH];
        end
      end
      mean_ring[ring_ptr] = 8'(mean);
      addr_ring[ring_ptr] = addr;
      ring_ptr = (ring_ptr + 1) % HISTORY_DEPTH;
      if (rows_held < HISTORY_DEPTH) rows_held++;
      row_sum = 0;
    end
    if (closes_window) begin
      has_result = 1'b1;
      res.found = hit_seen;
      res.row = hit_seen ? hit_addr : '0;
      row_sum = 0;
      rows_held = 0;
      hit_seen = 1'b0;
      hit_addr = '0;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
    mismatches++;
  endtask

  task automatic send_pixel(logic [7:0] pix, logic [11:0] addr, bit closes_row,
                            bit closes_window, bit typed = 1'b0,
                            edge_result_t typed_res = '0);
    int unsigned gap;
    bit has_result;
    edge_result_t res;
    gap = sender_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= pix;
    row_address <= addr;
    row_end <= closes_row;
    window_end <= closes_window;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_pixel(pix, addr, closes_row, closes_window, has_result, res);
    if (has_result) begin
      if (typed) res = typed_res;
      expected_edges.push_back(res);
      windows_sent++;
    end
    pixels_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_edges.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] thr, logic [6:0] cmp_dist, logic [8:0] width);
    cfg_we <= 1'b1;
    cfg_index <= REG_EDGE_THRESHOLD;
    cfg_data <= CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_index <= REG_COMPARE_DISTANCE;
    cfg_data <= CFG_DATA_W'(cmp_dist);
    @(posedge clk);
    cfg_index <= REG_WINDOW_WIDTH;
    cfg_data <= width;
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_reg = thr;
    dist_reg = cmp_dist;
    width_reg = width;
  endtask

  // Well-formed windows hold a bright run of rows followed by a dark run, so that
  // drops appear at a random row; noise windows are random but end the window.
  task automatic send_window(bit well_formed, bit first_window);
    int unsigned rows;
    int unsigned drop_at;
    int unsigned len;
    logic [7:0] bright;
    logic [7:0] dark;
    logic [7:0] level;
    logic [7:0] pix;
    logic [11:0] addr;
    bit last_px;
    bit last_row;
    if (!well_formed) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        send_pixel(8'($urandom), 12'($urandom), $urandom_range(0, 2) == 0, i == len - 1);
      end
      return;
    end
    rows = effective_distance() + $urandom_range(1, 6);
    drop_at = $urandom_range(0, rows - 1);
    bright = 8'($urandom_range(96, 255));
    dark = 8'($urandom_range(0, 95));
    addr = 12'($urandom);
    for (int r = 0; r < rows; r++) begin
      len = (effective_distance() >= 32) ? 1 : $urandom_range(1, 3);
      if (width_reg == 9'd256 && first_window && r == 0) len = 270;
      level = (r < drop_at) ? bright : dark;
      last_row = (r == rows - 1);
      for (int i = 0; i < len; i++) begin
        last_px = (i == len - 1);
        pix = (len > 255) ? 8'($urandom_range(252, 255)) : level ^ 8'($urandom_range(0, 7));
        send_pixel(pix, last_px ? addr : 12'($urandom),
                   last_px && (!last_row || $urandom_range(0, 1) == 1), last_px && last_row);
      end
      addr = addr + 12'd1;
    end
  endtask

  always @(posedge clk) begin : result_side
    edge_result_t want;
    int unsigned stall;
    if (rst) begin
      out_ready <= 1'b0;
      hold_cycles <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_edges.size() == 0) begin
        report_mismatch("result with no window pending", edge_row, 0);
      end else begin
        want = expected_edges.pop_front();
        if (edge_found !== want.found) report_mismatch("edge_found", edge_found, want.found);
        if (edge_row !== want.row) report_mismatch("edge_row", edge_row, want.row);
      end
      if ($urandom_range(0, 15) == 0) receiver_burst = !receiver_burst;
      stall = receiver_burst ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ready <= 1'b0;
        hold_cycles <= stall - 1;
      end
    end else if (!out_ready) begin
      if (hold_cycles == 0) out_ready <= 1'b1;
      else hold_cycles <= hold_cycles - 1;
    end
  end

  initial begin
    plan_step_t step;
    edge_result_t typed_res;
    int unsigned phase;
    int unsigned windows_in_phase;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_EDGE_THRESHOLD;
    cfg_data <= '0;
    in_valid <= 1'b0;
    pixel <= '0;
    row_address <= '0;
    row_end <= 1'b0;
    window_end <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_PLAN[i]) begin
      step = DIRECTED_PLAN[i];
      if (step.kind == STEP_CONFIG) begin
        wait_idle();
        set_config(step.thr, step.cmp_dist, step.width);
      end else begin
        typed_res.found = step.found;
        typed_res.row = step.row;
        send_pixel(step.pix, step.addr, step.closes_row, step.closes_window, step.typed,
                   typed_res);
      end
    end

    pixels_sent = 0;
    windows_sent = 0;
    phase = 0;
    while (pixels_sent < RANDOM_ITEMS || windows_sent < RANDOM_WINDOWS) begin
      wait_idle();
      if (phase < FIXED_PHASES) begin
        set_config(FIXED_THR[phase], FIXED_DIST[phase], FIXED_WIDTH[phase]);
      end else begin
        set_config(8'($urandom_range(0, 60)), 7'($urandom_range(1, 6)),
                   9'($urandom_range(1, 4)));
      end
      windows_in_phase = (effective_distance() >= 32) ? 1 : $urandom_range(3, 6);
      for (int w = 0; w < windows_in_phase; w++) begin
        sender_burst = ($urandom_range(0, 3) == 0);
        send_window($urandom_range(0, 4) != 0, w == 0);
      end
      phase++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/rpef_pkg.sv
src/rpef_front.sv
src/rpef_queue.sv
src/rpef_back.sv
src/row_projection_edge_finder_top.sv
src/rpef_checker.sv
dv/tb_row_projection_edge_finder_top.sv
